>>> design/local_maximum_3x3_detector_macros.svh
// ----------------------------------------------------------------------------
// local_maximum_3x3_detector_macros
// Assertion macros shared by the 3x3 local maximum detector.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MAXIMUM_3X3_DETECTOR_MACROS_SVH
`define LOCAL_MAXIMUM_3X3_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LMAX3_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LMAX3_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/lmax3_pkg.sv
// ----------------------------------------------------------------------------
// lmax3_pkg
// Types and constants of the 3x3 local maximum detector.
// ----------------------------------------------------------------------------
package lmax3_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int MAX_ROWS   = 128;
	localparam int MAX_COLS   = 128;
	localparam int ROW_BITS   = $clog2(MAX_ROWS);
	localparam int COL_BITS   = $clog2(MAX_COLS);
	localparam int CFG_BITS   = 8;
	localparam int WIN        = 3;
	localparam int OUT_BITS   = PIXEL_BITS + ROW_BITS + COL_BITS;
	localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;
	localparam int OUT_PAD    = OUT_BYTES * 8 - OUT_BITS;

	localparam logic [CFG_BITS-1:0] ROWS_LIMIT = CFG_BITS'(MAX_ROWS);
	localparam logic [CFG_BITS-1:0] COLS_LIMIT = CFG_BITS'(MAX_COLS);

	typedef enum logic {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} reg_index_t;

	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef logic [ROW_BITS-1:0]   row_t;
	typedef logic [COL_BITS-1:0]   col_t;
	typedef logic [CFG_BITS-1:0]   cfg_t;

	typedef pix_t win_t [WIN][WIN];

	// One line store entry: the pixels of the two rows above at one column.
	typedef struct packed {
		pix_t above1;
		pix_t above2;
	} line_entry_t;

	typedef struct packed {
		logic [OUT_PAD-1:0] pad;
		col_t               max_col;
		row_t               max_row;
		pix_t               max_value;
	} result_t;

endpackage

>>> design/local_maximum_3x3_detector.sv
// ----------------------------------------------------------------------------
// local_maximum_3x3_detector
// Strict 3x3 local maximum detection over a raster-order pixel stream.
// ----------------------------------------------------------------------------
//  channel | direction | payload (lowest bit first)
//  s_axis  | in        | pixel_value[15:0]
//  m_axis  | out       | max_value[15:0], max_row[22:16], max_col[29:23], zero[31:30]
//  cfg     | in        | cfg_index selects num_rows / num_cols, cfg_data[7:0]
//
//  One pixel per cycle while no stall holds the input; a result passes through
//  the stage 1, stage 2 and output registers after its completing pixel is taken.
//  The line store is one memory, one column per entry, read on accept and
//  written back when stage 1 moves on; a one-column frame uses the write bypass.
//  Reset clears control state only; the line store needs no clearing pass.
//  Input stalls only while a new result meets a held, untaken one.
// ----------------------------------------------------------------------------
`include "local_maximum_3x3_detector_macros.svh"

module local_maximum_3x3_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [lmax3_pkg::PIXEL_BITS-1:0] s_axis_tdata,   // pixel_value
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [lmax3_pkg::OUT_BYTES*8-1:0] m_axis_tdata,  // max_value, max_row, max_col
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [lmax3_pkg::CFG_BITS-1:0] cfg_data
);

	lmax3_pkg::cfg_t rows_q, cols_q;
	lmax3_pkg::row_t rows_m1, row_q;
	lmax3_pkg::col_t cols_m1, col_q;

	lmax3_pkg::line_entry_t line_mem [lmax3_pkg::MAX_COLS];
	lmax3_pkg::line_entry_t rd_s1, wr_entry;

	logic            valid_s1, valid_s2;
	lmax3_pkg::pix_t pix_s1;
	lmax3_pkg::row_t row_s1, row_s2;
	lmax3_pkg::col_t col_s1, col_s2;
	lmax3_pkg::win_t win_q;

	logic            adv, in_acc, wr_en, fwd, load;
	logic [2:0]      er, ec;
	logic            last_row, last_col, found_s2, use_row, use_col;
	lmax3_pkg::result_t res, out_q;
	logic            out_valid_q;

	function automatic logic is_peak(input lmax3_pkg::win_t w, input logic [2:0] re,
			input logic [2:0] ce, input int ci, input int cj);
		logic ok;
		int   a, b;
		ok = 1'b1;
		for (a = 0; a < lmax3_pkg::WIN; a++) begin
			for (b = 0; b < lmax3_pkg::WIN; b++) begin
				if ((a != ci || b != cj) && a >= ci - 1 && a <= ci + 1 &&
						b >= cj - 1 && b <= cj + 1 && re[a] && ce[b] &&
						w[a][b] >= w[ci][cj]) begin
					ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

	// Clamp the frame size: zero acts as one, above the limit saturates.
	always_comb begin
		lmax3_pkg::cfg_t r_m1, c_m1;
		if (rows_q == '0) begin
			r_m1 = '0;
		end else if (rows_q > lmax3_pkg::ROWS_LIMIT) begin
			r_m1 = lmax3_pkg::ROWS_LIMIT - 1'b1;
		end else begin
			r_m1 = rows_q - 1'b1;
		end
		if (cols_q == '0) begin
			c_m1 = '0;
		end else if (cols_q > lmax3_pkg::COLS_LIMIT) begin
			c_m1 = lmax3_pkg::COLS_LIMIT - 1'b1;
		end else begin
			c_m1 = cols_q - 1'b1;
		end
		rows_m1 = r_m1[lmax3_pkg::ROW_BITS-1:0];
		cols_m1 = c_m1[lmax3_pkg::COL_BITS-1:0];
	end

	// Config registers and pixel position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= lmax3_pkg::ROWS_LIMIT;
			cols_q <= lmax3_pkg::COLS_LIMIT;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lmax3_pkg::REG_NUM_ROWS: rows_q <= cfg_data;
				lmax3_pkg::REG_NUM_COLS: cols_q <= cfg_data;
				default: ;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (col_q == cols_m1) begin
				col_q <= '0;
				row_q <= (row_q == rows_m1) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign adv           = !(valid_s2 && found_s2 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = adv;
	assign in_acc        = s_axis_tvalid && adv;
	assign wr_en         = adv && valid_s1;
	assign fwd           = wr_en && (col_s1 == col_q);
	assign wr_entry      = '{above1: pix_s1, above2: rd_s1.above1};

	// Line store: read on accept, write back as stage 1 advances, bypass on a hit.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[col_s1] <= wr_entry;
		end
		if (in_acc) begin
			rd_s1 <= fwd ? wr_entry : line_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= s_axis_tdata;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
		if (wr_en) begin
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			for (int i = 0; i < lmax3_pkg::WIN; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd_s1.above2;
			win_q[1][2] <= rd_s1.above1;
			win_q[2][2] <= pix_s1;
		end
	end

	// Decide the candidates in raster order; the first peak wins.
	always_comb begin
		last_row = (row_s2 == rows_m1);
		last_col = (col_s2 == cols_m1);
		er = {1'b1, row_s2 != '0, row_s2[lmax3_pkg::ROW_BITS-1:1] != '0};
		ec = {1'b1, col_s2 != '0, col_s2[lmax3_pkg::COL_BITS-1:1] != '0};
		found_s2 = 1'b1;
		use_row  = 1'b0;
		use_col  = 1'b0;
		if (er[1] && ec[1] && is_peak(win_q, er, ec, 1, 1)) begin
			use_row = 1'b0;
			use_col = 1'b0;
		end else if (er[1] && last_col && is_peak(win_q, er, ec, 1, 2)) begin
			use_row = 1'b0;
			use_col = 1'b1;
		end else if (last_row && ec[1] && is_peak(win_q, er, ec, 2, 1)) begin
			use_row = 1'b1;
			use_col = 1'b0;
		end else if (last_row && last_col && is_peak(win_q, er, ec, 2, 2)) begin
			use_row = 1'b1;
			use_col = 1'b1;
		end else begin
			found_s2 = 1'b0;
		end
		res.pad     = '0;
		res.max_row = use_row ? row_s2 : row_s2 - 1'b1;
		res.max_col = use_col ? col_s2 : col_s2 - 1'b1;
		case ({use_row, use_col})
			2'b00:   res.max_value = win_q[1][1];
			2'b01:   res.max_value = win_q[1][2];
			2'b10:   res.max_value = win_q[2][1];
			default: res.max_value = win_q[2][2];
		endcase
	end

	assign load = adv && valid_s2 && found_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	`LMAX3_ASSERT_IMP(a_pos_in_frame, 1'b1, (row_q <= rows_m1) && (col_q <= cols_m1),
		"pixel position outside the frame")
	`LMAX3_ASSERT_IMP(a_no_overwrite, out_valid_q && !m_axis_tready, !load,
		"held result overwritten")
	`LMAX3_ASSERT_IMP(a_single_pixel,
		valid_s2 && rows_m1 == '0 && cols_m1 == '0 && row_s2 == '0 && col_s2 == '0,
		found_s2, "single-pixel frame not reported")
	`LMAX3_ASSERT_NXT(a_stall_holds, !adv,
		valid_s2 && $stable(row_s2) && $stable(col_s2), "stalled stage moved")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams raster frames through the 3x3 local maximum detector and checks
// every reported maximum against a cycle-free model of the same window logic.
// Frame sizes are reprogrammed between bursts, including zero, saturating and
// one-row/one-column shapes; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT  = 400_000;
	localparam int RANDOM_ITEMS = 460;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		lmax3_pkg::pix_t value;
		lmax3_pkg::row_t row;
		lmax3_pkg::col_t col;
	} peak_t;

	class peak_scoreboard;
		lmax3_pkg::pix_t frame_rows [3][lmax3_pkg::MAX_COLS];
		lmax3_pkg::cfg_t rows_reg;
		lmax3_pkg::cfg_t cols_reg;
		int              row_pos;
		int              col_pos;
		peak_t           expected_peaks [$];
		int unsigned     errors;
		int unsigned     peaks_seen;

		function new();
			rows_reg   = lmax3_pkg::cfg_t'(lmax3_pkg::MAX_ROWS);
			cols_reg   = lmax3_pkg::cfg_t'(lmax3_pkg::MAX_COLS);
			row_pos    = 0;
			col_pos    = 0;
			errors     = 0;
			peaks_seen = 0;
		endfunction

		function int clamp_count(lmax3_pkg::cfg_t v, int limit);
			if (v == 0)
				return 1;
			if (v > limit)
				return limit;
			return v;
		endfunction

		function int active_rows();
			return clamp_count(rows_reg, lmax3_pkg::MAX_ROWS);
		endfunction

		function int active_cols();
			return clamp_count(cols_reg, lmax3_pkg::MAX_COLS);
		endfunction

		function int pending();
			return expected_peaks.size();
		endfunction

		task report(string msg);
			if (errors < 50)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function void set_register(lmax3_pkg::reg_index_t idx, lmax3_pkg::cfg_t val);
			if (idx == lmax3_pkg::REG_NUM_ROWS)
				rows_reg = val;
			else
				cols_reg = val;
			row_pos = 0;
			col_pos = 0;
		endfunction

		function bit is_strict_peak(int i, int j, int rows, int cols);
			lmax3_pkg::pix_t center;
			int              ni;
			int              nj;
			center = frame_rows[i % 3][j];
			for (int di = -1; di <= 1; di++) begin
				for (int dj = -1; dj <= 1; dj++) begin
					ni = i + di;
					nj = j + dj;
					if (di == 0 && dj == 0)
						continue;
					if (ni < 0 || nj < 0 || ni >= rows || nj >= cols)
						continue;
					if (frame_rows[ni % 3][nj] >= center)
						return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function void note_pixel(lmax3_pkg::pix_t v);
			int    rows;
			int    cols;
			int    r;
			int    c;
			int    ci [2];
			int    cj [2];
			int    nr;
			int    nc;
			bit    found;
			peak_t p;
			rows = active_rows();
			cols = active_cols();
			if (row_pos >= rows || col_pos >= cols) begin
				row_pos = 0;
				col_pos = 0;
			end
			r  = row_pos;
			c  = col_pos;
			frame_rows[r % 3][c] = v;
			nr = 0;
			nc = 0;
			if (r >= 1) begin
				ci[nr] = r - 1;
				nr++;
			end
			if (r == rows - 1) begin
				ci[nr] = r;
				nr++;
			end
			if (c >= 1) begin
				cj[nc] = c - 1;
				nc++;
			end
			if (c == cols - 1) begin
				cj[nc] = c;
				nc++;
			end
			found = 1'b0;
			for (int a = 0; a < nr && !found; a++) begin
				for (int b = 0; b < nc && !found; b++) begin
					if (is_strict_peak(ci[a], cj[b], rows, cols)) begin
						p.value = frame_rows[ci[a] % 3][cj[b]];
						p.row   = lmax3_pkg::row_t'(ci[a]);
						p.col   = lmax3_pkg::col_t'(cj[b]);
						expected_peaks.push_back(p);
						found = 1'b1;
					end
				end
			end
			if (c + 1 < cols) begin
				col_pos = c + 1;
			end else begin
				col_pos = 0;
				row_pos = (r + 1 < rows) ? r + 1 : 0;
			end
		endfunction

		task check_result(logic [lmax3_pkg::OUT_BYTES*8-1:0] data);
			lmax3_pkg::result_t got;
			peak_t              want;
			got = lmax3_pkg::result_t'(data);
			peaks_seen++;
			if (expected_peaks.size() == 0) begin
				report($sformatf("unexpected maximum value=%h row=%0d col=%0d",
					got.max_value, got.max_row, got.max_col));
			end else begin
				want = expected_peaks.pop_front();
				if (got.max_value !== want.value)
					report($sformatf("max_value %h, expected %h", got.max_value, want.value));
				if (got.max_row !== want.row)
					report($sformatf("max_row %0d, expected %0d", got.max_row, want.row));
				if (got.max_col !== want.col)
					report($sformatf("max_col %0d, expected %0d", got.max_col, want.col));
			end
		endtask
	endclass

	logic                                  clk           = 1'b0;
	logic                                  arst_n        = 1'b0;
	logic                                  s_axis_tvalid = 1'b0;
	logic                                  s_axis_tready;
	logic [lmax3_pkg::PIXEL_BITS-1:0]      s_axis_tdata  = '0;
	logic                                  m_axis_tvalid;
	logic                                  m_axis_tready = 1'b0;
	logic [lmax3_pkg::OUT_BYTES*8-1:0]     m_axis_tdata;
	logic                                  cfg_we        = 1'b0;
	logic                                  cfg_index     = lmax3_pkg::REG_NUM_ROWS;
	logic [lmax3_pkg::CFG_BITS-1:0]        cfg_data      = '0;

	peak_scoreboard sb = new();
	int unsigned    cycle_count   = 0;
	int unsigned    pixels_sent   = 0;
	int unsigned    settings_used = 0;
	bit             calm          = 1'b0;

	local_maximum_3x3_detector i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	function automatic int unsigned idle_cycles();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result side: ready stretches broken by stalls of random length
	initial begin : drain_side
		int unsigned n;
		forever begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
			m_axis_tready <= 1'b1;
			repeat (n) @(posedge clk);
			n = idle_cycles();
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_pixel(lmax3_pkg::pix_t v);
		int unsigned gap;
		gap = calm ? 0 : idle_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_pixel(v);
		pixels_sent++;
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
	endtask

	// hold until every expected maximum is out, then let the pipeline empty
	task automatic settle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(bit do_rows, lmax3_pkg::cfg_t rows, bit do_cols,
			lmax3_pkg::cfg_t cols);
		if (do_rows) begin
			cfg_we    <= 1'b1;
			cfg_index <= lmax3_pkg::REG_NUM_ROWS;
			cfg_data  <= rows;
			@(posedge clk);
			sb.set_register(lmax3_pkg::REG_NUM_ROWS, rows);
		end
		if (do_cols) begin
			cfg_we    <= 1'b1;
			cfg_index <= lmax3_pkg::REG_NUM_COLS;
			cfg_data  <= cols;
			@(posedge clk);
			sb.set_register(lmax3_pkg::REG_NUM_COLS, cols);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic lmax3_pkg::cfg_t pick_count();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return lmax3_pkg::cfg_t'($urandom_range(1, 5));
		if (pick < 70)
			return lmax3_pkg::cfg_t'($urandom_range(6, 20));
		if (pick < 78)
			return '0;
		if (pick < 88)
			return lmax3_pkg::cfg_t'(lmax3_pkg::MAX_ROWS);
		if (pick < 94)
			return lmax3_pkg::cfg_t'($urandom_range(129, 255));
		return lmax3_pkg::cfg_t'($urandom_range(21, 127));
	endfunction

	function automatic lmax3_pkg::pix_t make_pixel(int unsigned style);
		if (style == 0)
			return lmax3_pkg::pix_t'($urandom_range(0, 16'hFFFF));
		if (style == 1)
			return lmax3_pkg::pix_t'($urandom_range(0, 3));
		case ($urandom_range(0, 2))
			0: return '0;
			1: return '1;
			default: return lmax3_pkg::pix_t'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	initial begin : main
		int unsigned     style;
		int unsigned     count;
		int unsigned     frame_size;
		int unsigned     frames;
		int unsigned     pick;
		int unsigned     random_start;
		int unsigned     left;
		lmax3_pkg::cfg_t rows;
		lmax3_pkg::cfg_t cols;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: full-width rows, enough pixels to decide the first row
		for (int k = 0; k < 2 * lmax3_pkg::MAX_COLS + 10; k++)
			send_pixel(lmax3_pkg::pix_t'($urandom_range(0, 16'hFFFF)));
		end_burst();
		settle();

		// one-pixel frames: zero row count acts as one
		configure(1'b1, '0, 1'b1, 8'd1);
		send_pixel('0);
		send_pixel('1);
		end_burst();
		settle();

		// 3x3: single peak in the center, then a flat frame where ties kill all
		configure(1'b1, 8'd3, 1'b1, 8'd3);
		for (int k = 0; k < 9; k++)
			send_pixel((k == 4) ? '1 : '0);
		for (int k = 0; k < 9; k++)
			send_pixel(16'h1234);
		end_burst();
		settle();

		// single row with a tie at the left edge
		configure(1'b1, 8'd1, 1'b1, 8'd3);
		send_pixel(16'd5);
		send_pixel(16'd5);
		send_pixel(16'd0);
		end_burst();

		random_start = pixels_sent;
		while (pixels_sent - random_start < RANDOM_ITEMS) begin
			settle();
			rows = pick_count();
			cols = pick_count();
			pick = $urandom_range(0, 9);
			configure(pick < 8, rows, 1'b1, cols);
			if (pick >= 8) begin
				@(posedge clk);
				configure(1'b1, rows, 1'b0, cols);
			end
			calm  = ($urandom_range(0, 3) == 0);
			pick  = $urandom_range(0, 9);
			style = (pick < 5) ? 0 : (pick < 8) ? 1 : 2;
			frame_size = sb.active_rows() * sb.active_cols();
			if (frame_size <= 400) begin
				frames = 400 / frame_size;
				if (frames > 3)
					frames = 3;
				count = frame_size * $urandom_range(1, frames);
				// drop the tail of the burst now and then; the next write restarts
				if (count > 1 && $urandom_range(0, 6) == 0)
					count = $urandom_range(1, count - 1);
			end else begin
				count = $urandom_range((2 * sb.active_cols() + 2 < 400) ?
					2 * sb.active_cols() + 2 : 400, 400);
			end
			left = RANDOM_ITEMS - (pixels_sent - random_start);
			if (count > left)
				count = left;
			for (int k = 0; k < count; k++)
				send_pixel(make_pixel(style));
			end_burst();
		end

		calm = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected maxima never arrived", sb.pending()));

		$display("Run covered %0d pixels under %0d frame settings.", pixels_sent,
			settings_used);
		$display("Local maxima compared: %0d, mismatches: %0d.", sb.peaks_seen, sb.errors);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles.", cycle_count);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
